@@ sv/icmpm_pkg.sv @@
// Shared types and constants for the ICMP response matcher.
// Used by the register block, the byte parser and the top level.
package icmpm_pkg;

  localparam int MAX_PACKET_BYTES = 1024;
  localparam int CNT_W            = $clog2(MAX_PACKET_BYTES + 1);
  localparam int ICMP_HDR_BYTES   = 8;
  localparam int HLEN_W           = 6;
  localparam int ADDR_W           = 4;
  localparam int DATA_W           = 32;

  // Byte offsets of the id and sequence fields within an ICMP header.
  localparam logic [CNT_W-1:0] REL_ID_HI  = CNT_W'(4);
  localparam logic [CNT_W-1:0] REL_ID_LO  = CNT_W'(5);
  localparam logic [CNT_W-1:0] REL_SEQ_HI = CNT_W'(6);
  localparam logic [CNT_W-1:0] REL_SEQ_LO = CNT_W'(7);

  localparam logic [7:0] TE_TYPE_RESET = 8'd11;

  typedef enum logic [1:0] {
    REG_EXPECTED_ID   = 2'd0,
    REG_EXPECTED_SEQ  = 2'd1,
    REG_ECHO_TYPE     = 2'd2,
    REG_TE_TYPE       = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_ACCEPTED     = 2'd0,
    ST_TOO_SHORT    = 2'd1,
    ST_UNKNOWN_TYPE = 2'd2,
    ST_MISMATCH     = 2'd3
  } status_t;

  typedef struct packed {
    logic [15:0] expected_id;
    logic [15:0] expected_seq;
    logic [7:0]  echo_type;
    logic [7:0]  te_type;
  } cfg_t;

  typedef struct packed {
    status_t     status;
    logic        is_te;
    logic [31:0] source;
  } res_t;

endpackage

@@ sv/icmpm_cfg_regs.sv @@
// APB-style configuration registers of the ICMP response matcher.
// Depends on icmpm_pkg for the register map and the cfg_t bundle.
module icmpm_cfg_regs import icmpm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_EXPECTED_ID:  cfg_nxt.expected_id  = pwdata[15:0];
        REG_EXPECTED_SEQ: cfg_nxt.expected_seq = pwdata[15:0];
        REG_ECHO_TYPE:    cfg_nxt.echo_type    = pwdata[7:0];
        REG_TE_TYPE:      cfg_nxt.te_type      = pwdata[7:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_EXPECTED_ID:  prdata = {16'h0000, cfg_r.expected_id};
      REG_EXPECTED_SEQ: prdata = {16'h0000, cfg_r.expected_seq};
      REG_ECHO_TYPE:    prdata = {24'h000000, cfg_r.echo_type};
      REG_TE_TYPE:      prdata = {24'h000000, cfg_r.te_type};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.expected_id  <= '0;
      cfg_r.expected_seq <= '0;
      cfg_r.echo_type    <= '0;
      cfg_r.te_type      <= TE_TYPE_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

@@ sv/icmpm_parser.sv @@
// Per-packet parse state of the ICMP response matcher and the result logic.
// Depends on icmpm_pkg; the result is registered by the top level.
module icmpm_parser import icmpm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       step,
  input  logic [7:0] pkt_byte,
  input  logic       last,
  output res_t       res
);

  logic [CNT_W-1:0]  count_r,  count_nxt;
  logic [HLEN_W-1:0] ohb_r,    ohb_nxt;
  logic [7:0]        mtype_r,  mtype_nxt;
  logic [HLEN_W-1:0] ihb_r,    ihb_nxt;
  logic [15:0]       id_r,     id_nxt;
  logic [15:0]       seq_r,    seq_nxt;
  logic [31:0]       src_r,    src_nxt;
  logic [1:0]        seen_r,   seen_nxt;

  logic [HLEN_W-1:0] h;
  logic [CNT_W-1:0]  h_ext;
  logic [CNT_W-1:0]  ib;
  logic [CNT_W-1:0]  base;
  logic [CNT_W-1:0]  rel;
  logic              in_range;
  logic              is_echo;
  logic              is_te;
  logic              take_en;
  logic              have_type;
  logic              fin_echo;
  logic              fin_te;

  assign h        = (count_r == '0) ? {pkt_byte[3:0], 2'b00} : ohb_r;
  assign h_ext    = CNT_W'(h);
  assign ib       = h_ext + CNT_W'(ICMP_HDR_BYTES);
  assign base     = ib + CNT_W'(ihb_r);
  assign in_range = count_r < CNT_W'(MAX_PACKET_BYTES);
  // Classification during the packet uses the type held before this byte.
  assign is_echo  = (mtype_r == cfg.echo_type);
  assign is_te    = !is_echo && (mtype_r == cfg.te_type);

  always_comb begin
    count_nxt = count_r;
    ohb_nxt   = ohb_r;
    mtype_nxt = mtype_r;
    ihb_nxt   = ihb_r;
    id_nxt    = id_r;
    seq_nxt   = seq_r;
    src_nxt   = src_r;
    seen_nxt  = seen_r;
    take_en   = 1'b0;
    rel       = count_r - h_ext;

    if (in_range) begin
      if (count_r == '0) ohb_nxt = h;
      if (count_r[CNT_W-1:2] == (CNT_W-2)'(3)) begin
        unique case (count_r[1:0])
          2'd0: src_nxt[31:24] = pkt_byte;
          2'd1: src_nxt[23:16] = pkt_byte;
          2'd2: src_nxt[15:8]  = pkt_byte;
          2'd3: src_nxt[7:0]   = pkt_byte;
        endcase
      end
      if (count_r == h_ext) mtype_nxt = pkt_byte;
      if (count_r > h_ext) begin
        if (is_echo) begin
          take_en = 1'b1;
        end else if (is_te) begin
          if (count_r == ib) begin
            ihb_nxt = {pkt_byte[3:0], 2'b00};
          end else if (count_r > base) begin
            take_en = 1'b1;
            rel     = count_r - base;
          end
        end
      end
      if (take_en) begin
        if (rel == REL_ID_HI) begin
          id_nxt = {pkt_byte, 8'h00};
        end else if (rel == REL_ID_LO) begin
          id_nxt[7:0] = pkt_byte;
          seen_nxt[0] = 1'b1;
        end else if (rel == REL_SEQ_HI) begin
          seq_nxt = {pkt_byte, 8'h00};
        end else if (rel == REL_SEQ_LO) begin
          seq_nxt[7:0] = pkt_byte;
          seen_nxt[1] = 1'b1;
        end
      end
      count_nxt = count_r + CNT_W'(1);
    end

    // The closing verdict looks at the state including this byte.
    have_type  = count_nxt > h_ext;
    fin_echo   = have_type && (mtype_nxt == cfg.echo_type);
    fin_te     = have_type && !fin_echo && (mtype_nxt == cfg.te_type);
    res.is_te  = fin_te;
    res.source = src_nxt;
    priority if (count_nxt < ib) begin
      res.status = ST_TOO_SHORT;
    end else if (!fin_echo && !fin_te) begin
      res.status = ST_UNKNOWN_TYPE;
    end else if (fin_te && seen_nxt != 2'b11) begin
      res.status = ST_TOO_SHORT;
    end else if (id_nxt != cfg.expected_id || seq_nxt != cfg.expected_seq) begin
      res.status = ST_MISMATCH;
    end else begin
      res.status = ST_ACCEPTED;
    end

    if (last) begin
      count_nxt = '0;
      ohb_nxt   = '0;
      mtype_nxt = '0;
      ihb_nxt   = '0;
      id_nxt    = '0;
      seq_nxt   = '0;
      src_nxt   = '0;
      seen_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ohb_r   <= '0;
      mtype_r <= '0;
      ihb_r   <= '0;
      id_r    <= '0;
      seq_r   <= '0;
      src_r   <= '0;
      seen_r  <= '0;
    end else if (step) begin
      count_r <= count_nxt;
      ohb_r   <= ohb_nxt;
      mtype_r <= mtype_nxt;
      ihb_r   <= ihb_nxt;
      id_r    <= id_nxt;
      seq_r   <= seq_nxt;
      src_r   <= src_nxt;
      seen_r  <= seen_nxt;
    end
  end

endmodule

@@ sv/icmp_response_matcher.sv @@
// Channel   | Handshake            | Payload
// in        | in_valid / in_ready  | in_packet_byte, in_last_byte
// out       | out_valid / out_ready| out_status, out_is_time_exceeded, out_source_address
// config    | psel/penable/pwrite  | paddr, pwdata, prdata, pready
//
// One byte is taken every cycle unless a closing byte is stalled in the input register. The
// verdict of a packet is loaded into the output register at the edge at which its last
// byte leaves the input register.
// Reset (rst_n, synchronous) clears the parse state and loads the register defaults.
// A result held in the output register stalls only a closing byte in the input register.
// Top level of the ICMP response matcher; uses icmpm_pkg, icmpm_cfg_regs and icmpm_parser.
module icmp_response_matcher import icmpm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_packet_byte,
  input  logic              in_last_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_status,
  output logic              out_is_time_exceeded,
  output logic [31:0]       out_source_address,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t       cfg;
  res_t       res;
  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;
  logic       s1_adv;
  logic       out_valid_r, out_valid_nxt;
  res_t       out_res_r;

  icmpm_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  icmpm_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .step     (s1_adv),
    .pkt_byte (s1_byte_r),
    .last     (s1_last_r),
    .res      (res)
  );

  // Only a closing byte needs room in the output register; other bytes always drain.
  assign s1_adv   = s1_valid_r && (!s1_last_r || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (s1_adv) s1_valid_nxt = 1'b0;
    if (in_valid && in_ready) s1_valid_nxt = 1'b1;
    out_valid_nxt = out_valid_r;
    if (out_ready) out_valid_nxt = 1'b0;
    if (s1_adv && s1_last_r) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_packet_byte;
      s1_last_r <= in_last_byte;
    end
    if (s1_adv && s1_last_r) out_res_r <= res;
  end

  assign out_valid            = out_valid_r;
  assign out_status           = out_res_r.status;
  assign out_is_time_exceeded = out_res_r.is_te;
  assign out_source_address   = out_res_r.source;

`ifndef SYNTHESIS
  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && s1_last_r |=> out_valid_r)
    else $error("closing byte did not load a result");

  a_stall_holds_byte: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |=> s1_valid_r && $stable(s1_byte_r) && $stable(s1_last_r))
    else $error("stalled byte was lost or overwritten");

  a_unknown_not_te: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.status == ST_UNKNOWN_TYPE |-> !out_res_r.is_te)
    else $error("unknown type flagged as time exceeded");
`endif

endmodule

@@ tb/sv/icmp_response_matcher_tb.sv @@
// Self-checking testbench for the ICMP response matcher: byte stimulus, APB set-up,
// a cycle-free predictor of the verdict of each packet and an in-order result check.
// Depends on icmpm_pkg and the icmp_response_matcher top level only.
module icmp_response_matcher_tb import icmpm_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 2000;

  typedef enum int {PK_ECHO, PK_TE, PK_OTHER, PK_NOISE} pkt_kind_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [7:0]        in_packet_byte = '0;
  logic              in_last_byte = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [1:0]        out_status;
  logic              out_is_time_exceeded;
  logic [31:0]       out_source_address;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  // Register mirror.
  logic [15:0] match_id = '0;
  logic [15:0] match_seq = '0;
  logic [7:0]  echo_code = '0;
  logic [7:0]  te_code = TE_TYPE_RESET;

  // Parse state of the packet in flight.
  logic [CNT_W-1:0]  byte_cnt = '0;
  logic [HLEN_W-1:0] outer_hlen = '0;
  logic [7:0]        msg_type = '0;
  logic [HLEN_W-1:0] inner_hlen = '0;
  logic [15:0]       cap_id = '0;
  logic [15:0]       cap_seq = '0;
  logic [31:0]       cap_src = '0;
  logic [1:0]        fields_done = '0;

  res_t        verdicts_due[$];
  logic [7:0]  pkt_bytes[$];
  int          mismatch_count = 0;
  int          in_idle_pct = 0;
  int          out_stall_pct = 0;
  int          ready_hold_cycles = 0;
  int          quiet_cycles = 0;

  icmp_response_matcher i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_packet_byte       (in_packet_byte),
    .in_last_byte         (in_last_byte),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_status           (out_status),
    .out_is_time_exceeded (out_is_time_exceeded),
    .out_source_address   (out_source_address),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor
  function automatic void capture_field(int rel, logic [7:0] b);
    if (rel == REL_ID_HI) begin
      cap_id[15:8] = b;
    end else if (rel == REL_ID_LO) begin
      cap_id[7:0] = b;
      fields_done[0] = 1'b1;
    end else if (rel == REL_SEQ_HI) begin
      cap_seq[15:8] = b;
    end else if (rel == REL_SEQ_LO) begin
      cap_seq[7:0] = b;
      fields_done[1] = 1'b1;
    end
  endfunction

  function automatic void predict_verdict(logic [7:0] b, logic is_last);
    int   p, h, ib, base, total;
    logic is_echo, is_te, have_type, echo_hit, te_hit;
    res_t v;
    p = int'(byte_cnt);
    h = (p == 0) ? int'(b[3:0]) * 4 : int'(outer_hlen);
    is_echo = (msg_type == echo_code);
    is_te = !is_echo && (msg_type == te_code);
    if (p < MAX_PACKET_BYTES) begin
      if (p == 0) outer_hlen = HLEN_W'(h);
      if (p >= 12 && p <= 15) cap_src[(15 - p) * 8 +: 8] = b;
      if (p == h) msg_type = b;
      if (p > h) begin
        if (is_echo) begin
          capture_field(p - h, b);
        end else if (is_te) begin
          // The quoted header sits behind the ICMP header and the quoted IPv4 header.
          ib = h + ICMP_HDR_BYTES;
          if (p == ib) begin
            inner_hlen = HLEN_W'(int'(b[3:0]) * 4);
          end else if (p > ib) begin
            base = ib + int'(inner_hlen);
            if (p > base) capture_field(p - base, b);
          end
        end
      end
      byte_cnt = CNT_W'(p + 1);
    end
    if (is_last) begin
      total = int'(byte_cnt);
      have_type = (total > h);
      echo_hit = have_type && (msg_type == echo_code);
      te_hit = have_type && !echo_hit && (msg_type == te_code);
      v.is_te = te_hit;
      v.source = cap_src;
      if (total < h + ICMP_HDR_BYTES) v.status = ST_TOO_SHORT;
      else if (!echo_hit && !te_hit) v.status = ST_UNKNOWN_TYPE;
      else if (te_hit && fields_done != 2'b11) v.status = ST_TOO_SHORT;
      else if (cap_id != match_id || cap_seq != match_seq) v.status = ST_MISMATCH;
      else v.status = ST_ACCEPTED;
      verdicts_due = {verdicts_due, v};
      byte_cnt = '0;
      outer_hlen = '0;
      msg_type = '0;
      inner_hlen = '0;
      cap_id = '0;
      cap_seq = '0;
      cap_src = '0;
      fields_done = '0;
    end
  endfunction

  // ---------------------------------------------------------------- checking
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (verdicts_due.size() == 0) begin
        $display("%0t: unexpected result: status %0d te %0d source %h", $time, out_status,
                 out_is_time_exceeded, out_source_address);
        mismatch_count++;
      end else begin
        want = verdicts_due.pop_front();
        if (out_status !== want.status || out_is_time_exceeded !== want.is_te ||
            out_source_address !== want.source) begin
          $display("%0t: mismatch: expected status %0d te %0d source %h, got %0d %0d %h",
                   $time, want.status, want.is_te, want.source, out_status,
                   out_is_time_exceeded, out_source_address);
          mismatch_count++;
        end
      end
    end
  end

  // Receiver: random stalls, or a long hold-off when a test asks for one.
  always @(negedge clk) begin
    if (ready_hold_cycles > 0) begin
      out_ready = 1'b0;
      ready_hold_cycles--;
    end else begin
      out_ready = ($urandom_range(99) >= out_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- drivers
  task automatic send_byte(logic [7:0] b, logic is_last);
    @(negedge clk);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_packet_byte = b;
    in_last_byte = is_last;
    do @(posedge clk); while (!in_ready);
    predict_verdict(b, is_last);
  endtask

  task automatic send_packet();
    foreach (pkt_bytes[i]) send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    wait (verdicts_due.size() == 0);
    // The last verdict may still be leaving the output register.
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(reg_idx_t idx, logic [31:0] val);
    logic [31:0] mask;
    mask = (idx == REG_EXPECTED_ID || idx == REG_EXPECTED_SEQ) ? 32'hFFFF : 32'hFF;
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_EXPECTED_ID:  match_id = val[15:0];
      REG_EXPECTED_SEQ: match_seq = val[15:0];
      REG_ECHO_TYPE:    echo_code = val[7:0];
      REG_TE_TYPE:      te_code = val[7:0];
      default: ;
    endcase
    // Read the register back.
    @(negedge clk);
    penable = 1'b0;
    pwrite = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if ((prdata & mask) !== (val & mask)) begin
      $display("%0t: register %0d read back: expected %h, got %h", $time, idx, val & mask,
               prdata & mask);
      mismatch_count++;
    end
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic set_config(logic [15:0] id, logic [15:0] seq, logic [7:0] echo,
                            logic [7:0] te);
    wait_drained();
    cfg_write(REG_EXPECTED_ID, {16'($urandom), id});
    cfg_write(REG_EXPECTED_SEQ, {16'($urandom), seq});
    cfg_write(REG_ECHO_TYPE, {24'($urandom), echo});
    cfg_write(REG_TE_TYPE, {24'($urandom), te});
  endtask

  // ---------------------------------------------------------------- packets
  function automatic void poke(int idx, logic [7:0] v);
    if (idx < pkt_bytes.size()) pkt_bytes[idx] = v;
  endfunction

  // Lays out a packet of the given kind; cut, where non-zero, is the length it is cut to.
  function automatic void build_packet(pkt_kind_t kind, int ihl, int inner_ihl,
                                       logic [15:0] id, logic [15:0] seq, int extra, int cut);
    int          h, len, qb;
    logic [7:0]  odd_type;
    h = ihl * 4;
    qb = h + ICMP_HDR_BYTES + inner_ihl * 4;
    case (kind)
      PK_TE:    len = qb + ICMP_HDR_BYTES + extra;
      PK_NOISE: len = extra;
      default:  len = h + ICMP_HDR_BYTES + extra;
    endcase
    if (cut > 0) len = cut;
    pkt_bytes.delete();
    for (int i = 0; i < len; i++) pkt_bytes = {pkt_bytes, 8'($urandom)};
    if (kind == PK_NOISE) return;
    poke(0, {4'h4, 4'(ihl)});
    case (kind)
      PK_ECHO: begin
        poke(h, echo_code);
        poke(h + 4, id[15:8]);
        poke(h + 5, id[7:0]);
        poke(h + 6, seq[15:8]);
        poke(h + 7, seq[7:0]);
      end
      PK_TE: begin
        poke(h, te_code);
        poke(h + ICMP_HDR_BYTES, {4'h4, 4'(inner_ihl)});
        poke(qb + 4, id[15:8]);
        poke(qb + 5, id[7:0]);
        poke(qb + 6, seq[15:8]);
        poke(qb + 7, seq[7:0]);
      end
      default: begin
        odd_type = 8'($urandom);
        while (odd_type == echo_code || odd_type == te_code) odd_type = 8'($urandom);
        poke(h, odd_type);
      end
    endcase
  endfunction

  function automatic logic [15:0] pick_field(logic [15:0] want);
    int r;
    r = $urandom_range(9);
    if (r < 7) return want;
    if (r < 8) return want ^ (16'h1 << $urandom_range(15));
    return 16'($urandom);
  endfunction

  task automatic send_random_packet();
    int        r, ihl, inner_ihl, extra, cut;
    pkt_kind_t kind;
    r = $urandom_range(99);
    kind = (r < 45) ? PK_ECHO : (r < 80) ? PK_TE : (r < 90) ? PK_OTHER : PK_NOISE;
    ihl = $urandom_range(1) ? 5 : $urandom_range(15);
    inner_ihl = $urandom_range(1) ? 5 : $urandom_range(15);
    extra = (kind == PK_NOISE) ? $urandom_range(1, 40) : $urandom_range(8);
    cut = 0;
    build_packet(kind, ihl, inner_ihl, pick_field(match_id), pick_field(match_seq), extra, 0);
    // A tenth of the packets end early.
    if ($urandom_range(9) == 0) cut = $urandom_range(1, pkt_bytes.size());
    if (cut > 0) begin
      while (pkt_bytes.size() > cut) void'(pkt_bytes.pop_back());
    end
    send_packet();
  endtask

  // ---------------------------------------------------------------- tests
  task automatic test_directed();
    in_idle_pct = 0;
    out_stall_pct = 0;
    build_packet(PK_ECHO, 5, 5, match_id, match_seq, 4, 0);
    send_packet();
    build_packet(PK_ECHO, 5, 5, match_id ^ 16'h0001, match_seq, 4, 0);
    send_packet();
    build_packet(PK_ECHO, 5, 5, match_id, ~match_seq, 0, 0);
    send_packet();
    build_packet(PK_TE, 5, 5, match_id, match_seq, 2, 0);
    send_packet();
    // Time exceeded that stops one byte short of the quoted sequence number.
    build_packet(PK_TE, 5, 5, match_id, match_seq, 0, 20 + 8 + 20 + 7);
    send_packet();
    build_packet(PK_ECHO, 5, 5, match_id, match_seq, 0, 27);
    send_packet();
    build_packet(PK_OTHER, 5, 5, match_id, match_seq, 3, 0);
    send_packet();
    build_packet(PK_NOISE, 5, 5, match_id, match_seq, 1, 0);
    send_packet();
    // Header length zero: the type is the first byte itself.
    build_packet(PK_ECHO, 0, 5, match_id, match_seq, 0, 0);
    send_packet();
    build_packet(PK_ECHO, 15, 5, match_id, match_seq, 0, 0);
    send_packet();
    build_packet(PK_TE, 5, 0, match_id, match_seq, 0, 0);
    send_packet();
    build_packet(PK_TE, 15, 15, match_id, match_seq, 1, 0);
    send_packet();
    build_packet(PK_TE, 3, 2, match_id, match_seq, 0, 0);
    send_packet();
    // Source address only partly received.
    build_packet(PK_ECHO, 5, 5, match_id, match_seq, 0, 14);
    send_packet();
    build_packet(PK_NOISE, 5, 5, match_id, match_seq, 30, 0);
    foreach (pkt_bytes[i]) pkt_bytes[i] = 8'hFF;
    send_packet();
    foreach (pkt_bytes[i]) pkt_bytes[i] = 8'h00;
    send_packet();
  endtask

  task automatic test_type_precedence();
    in_idle_pct = 0;
    out_stall_pct = 0;
    build_packet(PK_ECHO, 5, 5, match_id, match_seq, 2, 0);
    send_packet();
    build_packet(PK_TE, 5, 5, match_id, match_seq, 2, 0);
    send_packet();
  endtask

  task automatic test_random(int n_bytes, int in_idle, int out_stall);
    int sent;
    in_idle_pct = in_idle;
    out_stall_pct = out_stall;
    sent = 0;
    while (sent < n_bytes) begin
      send_random_packet();
      sent += pkt_bytes.size();
    end
  endtask

  task automatic test_backpressure();
    in_idle_pct = 0;
    out_stall_pct = 0;
    ready_hold_cycles = 150;
    for (int i = 0; i < 12; i++) begin
      build_packet(PK_ECHO, 0, 5, match_id, match_seq, 0, (i % 3 == 0) ? 1 : 0);
      send_packet();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    set_config(16'h1234, 16'hABCD, 8'd0, 8'd11);
    test_directed();
    test_random(120, 0, 0);
    set_config(16'h0000, 16'h0000, 8'h00, 8'h00);
    test_random(120, 61, 0);
    set_config(16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
    test_type_precedence();
    test_random(120, 0, 61);
    set_config(16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom));
    test_random(120, 34, 34);
    test_backpressure();
    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && verdicts_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/icmpm_pkg.sv
sv/icmpm_cfg_regs.sv
sv/icmpm_parser.sv
sv/icmp_response_matcher.sv
tb/sv/icmp_response_matcher_tb.sv
